>>> design/ps2kse_pkg.sv
// Shared types, codes and byte-sequence tables for the PS/2 scancode engine.
package ps2kse_pkg;

  localparam int HeldSlots = 6;
  localparam int SlotW     = (HeldSlots > 1) ? $clog2(HeldSlots) : 1;

  localparam logic [1:0] CMD_PRESS       = 2'd0;
  localparam logic [1:0] CMD_RELEASE     = 2'd1;
  localparam logic [1:0] CMD_RELEASE_ALL = 2'd2;
  localparam logic [1:0] CMD_HOST        = 2'd3;

  localparam logic [7:0] PREFIX_SPECIAL = 8'hFF;
  localparam logic [7:0] SPECIAL_PRTSC  = 8'h01;
  localparam logic [7:0] SPECIAL_PAUSE  = 8'h02;

  localparam logic [7:0] BYTE_ACK   = 8'hFA;
  localparam logic [7:0] BYTE_BAT   = 8'hAA;
  localparam logic [7:0] BYTE_ID0   = 8'hAB;
  localparam logic [7:0] BYTE_ID1   = 8'h83;
  localparam logic [7:0] BYTE_BREAK = 8'hF0;
  localparam logic [7:0] BYTE_EXT0  = 8'hE0;
  localparam logic [7:0] BYTE_EXT1  = 8'hE1;
  localparam logic [7:0] BYTE_7C    = 8'h7C;
  localparam logic [7:0] BYTE_14    = 8'h14;
  localparam logic [7:0] BYTE_77    = 8'h77;
  localparam logic [7:0] BYTE_ECHO  = 8'hEE;
  localparam logic [7:0] BYTE_12    = 8'h12;

  localparam logic [7:0] HOST_RESET     = 8'hFF;
  localparam logic [7:0] HOST_RESEND    = 8'hFE;
  localparam logic [7:0] HOST_DEFAULTS  = 8'hF6;
  localparam logic [7:0] HOST_DISABLE   = 8'hF5;
  localparam logic [7:0] HOST_ENABLE    = 8'hF4;
  localparam logic [7:0] HOST_TYPEMATIC = 8'hF3;
  localparam logic [7:0] HOST_SCANSET   = 8'hF0;
  localparam logic [7:0] HOST_LEDS      = 8'hED;
  localparam logic [7:0] HOST_READ_ID   = 8'hF2;
  localparam logic [7:0] HOST_ECHO      = 8'hEE;

  typedef enum logic [3:0] {
    K_NONE,
    K_MAKE,
    K_MAKE_PFX,
    K_MAKE_PRTSC,
    K_MAKE_PAUSE,
    K_BRK,
    K_BRK_PFX,
    K_BRK_PRTSC,
    K_ACK,
    K_ACK_BAT,
    K_ID,
    K_ECHO
  } seq_kind_e;

  // Controller to datapath.
  typedef struct packed {
    logic latch;     // capture the input beat
    logic load;      // fetch the held key at the scan slot
    logic apply;     // update the table and pick the byte sequence
    logic step;      // produce the next byte of the sequence
    logic slot_dec;  // move the scan slot down
    logic flush;     // send the buffered byte as the final one
  } ps2kse_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic len_zero;   // the sequence about to be chosen is empty
    logic step_last;  // current byte is the last of the sequence
    logic slot_zero;  // scan slot is at index 0
    logic is_all;     // item is a release-all
  } ps2kse_stat_t;

  function automatic seq_kind_e make_kind(input logic [15:0] key);
    if (key[15:8] != PREFIX_SPECIAL) begin
      return (key[15:8] != 8'h00) ? K_MAKE_PFX : K_MAKE;
    end else if (key[7:0] == SPECIAL_PRTSC) begin
      return K_MAKE_PRTSC;
    end else if (key[7:0] == SPECIAL_PAUSE) begin
      return K_MAKE_PAUSE;
    end
    return K_NONE;
  endfunction

  function automatic seq_kind_e break_kind(input logic [15:0] key);
    if (key[15:8] != PREFIX_SPECIAL) begin
      return (key[15:8] != 8'h00) ? K_BRK_PFX : K_BRK;
    end else if (key[7:0] == SPECIAL_PRTSC) begin
      return K_BRK_PRTSC;
    end
    return K_NONE;
  endfunction

  function automatic seq_kind_e host_kind(input logic [7:0] b);
    case (b)
      HOST_RESET: return K_ACK_BAT;
      HOST_RESEND, HOST_DEFAULTS, HOST_DISABLE, HOST_ENABLE,
      HOST_TYPEMATIC, HOST_SCANSET, HOST_LEDS: return K_ACK;
      HOST_READ_ID: return K_ID;
      HOST_ECHO: return K_ECHO;
      default: return K_NONE;
    endcase
  endfunction

  function automatic logic host_takes_param(input logic [7:0] b);
    return (b == HOST_TYPEMATIC) || (b == HOST_SCANSET) || (b == HOST_LEDS);
  endfunction

  function automatic logic [3:0] seq_len(input seq_kind_e k);
    unique case (k)
      K_NONE:       return 4'd0;
      K_MAKE:       return 4'd1;
      K_MAKE_PFX:   return 4'd2;
      K_MAKE_PRTSC: return 4'd4;
      K_MAKE_PAUSE: return 4'd8;
      K_BRK:        return 4'd2;
      K_BRK_PFX:    return 4'd3;
      K_BRK_PRTSC:  return 4'd6;
      K_ACK:        return 4'd1;
      K_ACK_BAT:    return 4'd2;
      K_ID:         return 4'd3;
      K_ECHO:       return 4'd1;
      default:      return 4'd0;
    endcase
  endfunction

  function automatic logic [7:0] seq_byte(input seq_kind_e k, input logic [2:0] idx,
                                          input logic [15:0] key);
    logic [7:0] b;
    b = 8'h00;
    case (k)
      K_MAKE:     b = key[7:0];
      K_MAKE_PFX: b = (idx == 3'd0) ? key[15:8] : key[7:0];
      K_MAKE_PRTSC: begin
        case (idx)
          3'd0, 3'd2: b = BYTE_EXT0;
          3'd1:       b = BYTE_12;
          default:    b = BYTE_7C;
        endcase
      end
      K_MAKE_PAUSE: begin
        case (idx)
          3'd0, 3'd3: b = BYTE_EXT1;
          3'd1, 3'd5: b = BYTE_14;
          3'd4, 3'd6: b = BYTE_BREAK;
          default:    b = BYTE_77;
        endcase
      end
      K_BRK: b = (idx == 3'd0) ? BYTE_BREAK : key[7:0];
      K_BRK_PFX: begin
        case (idx)
          3'd0:    b = key[15:8];
          3'd1:    b = BYTE_BREAK;
          default: b = key[7:0];
        endcase
      end
      K_BRK_PRTSC: begin
        case (idx)
          3'd0, 3'd3: b = BYTE_EXT0;
          3'd1, 3'd4: b = BYTE_BREAK;
          3'd2:       b = BYTE_7C;
          default:    b = BYTE_12;
        endcase
      end
      K_ACK:     b = BYTE_ACK;
      K_ACK_BAT: b = (idx == 3'd0) ? BYTE_ACK : BYTE_BAT;
      K_ID: begin
        case (idx)
          3'd0:    b = BYTE_ACK;
          3'd1:    b = BYTE_ID0;
          default: b = BYTE_ID1;
        endcase
      end
      K_ECHO:  b = BYTE_ECHO;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> design/ps2kse_datapath.sv
// Datapath: held-key table, parameter flag, sequence bytes and the output beat.
module ps2kse_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [1:0]               command_i,
  input  logic [15:0]              key_code_i,
  input  logic [7:0]               host_byte_i,
  input  ps2kse_pkg::ps2kse_cmd_t  cmd_i,
  output ps2kse_pkg::ps2kse_stat_t stat_o,
  output logic                     strobe_o,
  output logic [7:0]               tx_byte_o,
  output logic                     last_o
);
  import ps2kse_pkg::*;

  logic [1:0]       op_q;
  logic [15:0]      key_q;
  logic [7:0]       host_q;
  logic [15:0]      held_q [HeldSlots];
  logic             pend_q;
  seq_kind_e        kind_q;
  logic [2:0]       idx_q;
  logic [SlotW-1:0] slot_q;
  logic [7:0]       buf_q;
  logic             buf_vld_q;
  logic             strobe_q;
  logic [7:0]       tx_q;
  logic             last_q;

  logic             hit, free_ok, act_press, act_rel, key_nz;
  logic [SlotW-1:0] hit_idx, free_idx;
  seq_kind_e        new_kind;
  logic [7:0]       cur_byte;
  logic [3:0]       idx_next;

  // Lowest matching slot and lowest free slot.
  always_comb begin
    hit      = 1'b0;
    free_ok  = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = HeldSlots - 1; i >= 0; i--) begin
      if (held_q[i] == key_q) begin
        hit     = 1'b1;
        hit_idx = SlotW'(i);
      end
      if (held_q[i] == 16'h0000) begin
        free_ok  = 1'b1;
        free_idx = SlotW'(i);
      end
    end
  end

  assign key_nz    = (key_q != 16'h0000);
  assign act_press = (op_q == CMD_PRESS) && key_nz && !hit && free_ok;
  assign act_rel   = ((op_q == CMD_RELEASE) || (op_q == CMD_RELEASE_ALL)) && key_nz && hit;

  always_comb begin
    new_kind = K_NONE;
    unique case (op_q)
      CMD_PRESS:                    new_kind = act_press ? make_kind(key_q) : K_NONE;
      CMD_RELEASE, CMD_RELEASE_ALL: new_kind = act_rel ? break_kind(key_q) : K_NONE;
      CMD_HOST:                     new_kind = pend_q ? K_ACK : host_kind(host_q);
      default:                      new_kind = K_NONE;
    endcase
  end

  assign cur_byte = seq_byte(kind_q, idx_q, key_q);
  assign idx_next = {1'b0, idx_q} + 4'd1;

  assign stat_o.len_zero  = (seq_len(new_kind) == 4'd0);
  assign stat_o.step_last = (idx_next == seq_len(kind_q));
  assign stat_o.slot_zero = (slot_q == '0);
  assign stat_o.is_all    = (op_q == CMD_RELEASE_ALL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HeldSlots; i++) begin
        held_q[i] <= 16'h0000;
      end
      pend_q    <= 1'b0;
      buf_vld_q <= 1'b0;
      strobe_q  <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      if (cmd_i.latch) begin
        buf_vld_q <= 1'b0;
      end
      if (cmd_i.apply) begin
        if (act_press) begin
          held_q[free_idx] <= key_q;
        end
        if (act_rel) begin
          held_q[hit_idx] <= 16'h0000;
        end
        if (op_q == CMD_HOST) begin
          pend_q <= pend_q ? 1'b0 : host_takes_param(host_q);
        end
      end
      if (cmd_i.step) begin
        // Hold each byte back by one so the final one can carry last.
        strobe_q  <= buf_vld_q;
        buf_vld_q <= 1'b1;
      end
      if (cmd_i.flush) begin
        strobe_q  <= buf_vld_q;
        buf_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= command_i;
      key_q  <= key_code_i;
      host_q <= host_byte_i;
      slot_q <= SlotW'(HeldSlots - 1);
    end
    if (cmd_i.load) begin
      key_q <= held_q[slot_q];
    end
    if (cmd_i.slot_dec) begin
      slot_q <= slot_q - SlotW'(1);
    end
    if (cmd_i.apply) begin
      kind_q <= new_kind;
      idx_q  <= 3'd0;
    end
    if (cmd_i.step) begin
      idx_q  <= idx_q + 3'd1;
      buf_q  <= cur_byte;
      tx_q   <= buf_q;
      last_q <= 1'b0;
    end
    if (cmd_i.flush) begin
      tx_q   <= buf_q;
      last_q <= 1'b1;
    end
  end

  assign strobe_o  = strobe_q;
  assign tx_byte_o = tx_q;
  assign last_o    = last_q;

endmodule

>>> design/ps2kse_ctrl.sv
// Controller: sequences table update, byte emission and the release-all scan.
module ps2kse_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  input  logic [1:0]               command_i,
  input  ps2kse_pkg::ps2kse_stat_t stat_i,
  output ps2kse_pkg::ps2kse_cmd_t  cmd_o,
  output logic                     busy
);
  import ps2kse_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_APPLY = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] after_key;

  // Where to go once one key's sequence is done.
  assign after_key = (stat_i.is_all && !stat_i.slot_zero) ? ST_SCAN : ST_FLUSH;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d     = (command_i == CMD_RELEASE_ALL) ? ST_SCAN : ST_APPLY;
        end
      end
      ST_SCAN: begin
        cmd_o.load = 1'b1;
        state_d    = ST_APPLY;
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        if (stat_i.len_zero) begin
          state_d = after_key;
          cmd_o.slot_dec = (after_key == ST_SCAN);
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.step = 1'b1;
        if (stat_i.step_last) begin
          state_d = after_key;
          cmd_o.slot_dec = (after_key == ST_SCAN);
        end
      end
      ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

>>> design/ps2_keyboard_scancode_engine_unit.sv
// Top level of the PS/2 keyboard scancode engine: controller plus datapath.
//
//  channel   direction  handshake                 payload
//  ------------------------------------------------------------------------------
//  event     in         start high, busy low      command_i, key_code_i, host_byte_i
//  reply     out        strobe_o for one cycle    tx_byte_o, last_o
//
// Work: a key press, key release or host byte sends a sequence of n bytes (up to 8);
// release-all sends a break sequence for each held key, the slots being visited
// one by one from the top down. The byte sequencer produces one byte a cycle.
// Reset: rst_ni clears the held-key table, the parameter flag and the state.
// Stalls: none on the output side; each reply beat is shown for one cycle.
// Each byte is held back in a buffer register so the final beat of an item carries last_o.
module ps2_keyboard_scancode_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [15:0] key_code_i,
  input  logic [7:0]  host_byte_i,
  output logic        strobe_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o
);
  import ps2kse_pkg::*;

  ps2kse_cmd_t  cmd;
  ps2kse_stat_t stat;

  // Sequence the work of one event beat.
  ps2kse_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .busy      (busy)
  );

  // Hold the key table and drive the reply beats.
  ps2kse_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .command_i   (command_i),
    .key_code_i  (key_code_i),
    .host_byte_i (host_byte_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .strobe_o    (strobe_o),
    .tx_byte_o   (tx_byte_o),
    .last_o      (last_o)
  );

endmodule
